/* sv/fetbf_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and a helper function of the free extent table.
package fetbf_pkg;

  localparam int unsigned MaxHoles  = 64;
  localparam int unsigned AddrBits  = 48;
  localparam int unsigned IdxW      = $clog2(MaxHoles);
  localparam int unsigned CntW      = $clog2(MaxHoles + 1);
  localparam int unsigned AlignW    = 5;
  localparam logic [AlignW-1:0] AlignReset = 5'd21;
  localparam logic [CntW-1:0]   NoPin      = CntW'(MaxHoles);

  typedef logic [AddrBits-1:0] addr_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_TAKE   = 2'd1,
    CMD_PURGE  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0] cmd;
    addr_t      base_addr;
    addr_t      length;
    addr_t      floor_addr;
  } in_item_t;

  typedef struct packed {
    addr_t           taken_addr;
    logic            took;
    logic            dropped;
    logic [CntW-1:0] hole_total;
  } out_item_t;

  typedef struct packed {
    addr_t s;
    addr_t l;
  } hole_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LATCH,
    OP_INS_INIT,
    OP_TK_INIT,
    OP_K0,
    OP_CLR,
    OP_KINC,
    OP_RD,
    OP_CALC,
    OP_PF_WR,
    OP_SET_DROP,
    OP_APPEND,
    OP_MG_INIT,
    OP_MG_WR,
    OP_DR_DEC,
    OP_RD_LAST,
    OP_DR_WR,
    OP_TK_EV,
    OP_RD_BEST,
    OP_TK_X1,
    OP_TK_X2,
    OP_TK_X3,
    OP_TK_X4,
    OP_HEAD_EXT,
    OP_TAIL_EXT,
    OP_TK_DONE,
    OP_DROPK,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e op;
  } ctl_t;

  typedef struct packed {
    cmd_e cmd;
    logic k_end;
    logic k_pin;
    logic k_skip;
    logic ext_zero;
    logic full;
    logic pf_hit;
    logic mg_hit;
    logic dr_last;
    logic have;
    logic head;
    logic tail_nz;
    logic pin_valid;
    logic purge_hit;
    logic out_free;
  } stat_t;

  function automatic addr_t round_up(addr_t v, logic [AlignW-1:0] lg);
    addr_t msk;
    msk = (addr_t'(1) << lg) - addr_t'(1);
    return (v + msk) & ~msk;
  endfunction

endpackage

/* sv/free_extent_table_best_fit.sv */
`timescale 1ns / 1ps
// Top level of the free extent table with best-fit take and coalescing.
//
// The block holds up to 64 free extents in a single-port memory and handles one
// item at a time, giving one result item per input item. Each table walk steps
// through the entries in index order, so a take or purge scans the whole table (a
// purge adds at most one memory move per purged hole) and an insert makes one pass
// to place the extent, plus one more after every merge; a take that puts back head and
// tail remainders runs up to two inserts after its scan. A new item is taken as soon
// as the previous result has been loaded into the output register.
module free_extent_table_best_fit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  fetbf_pkg::in_item_t   in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output fetbf_pkg::out_item_t  out_item_o
);

  logic [fetbf_pkg::AlignW-1:0] align_q;
  fetbf_pkg::ctl_t              ctl;
  fetbf_pkg::stat_t             st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      align_q <= fetbf_pkg::AlignReset;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      align_q <= pwdata[fetbf_pkg::AlignW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {{(32 - fetbf_pkg::AlignW){1'b0}}, align_q};

  fetbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .ctl_o      (ctl)
  );

  fetbf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .st_o        (st),
    .align_i     (align_q),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* sv/fetbf_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer of the free extent table: walks the table operations step by step.
module fetbf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  fetbf_pkg::stat_t st_i,
  output fetbf_pkg::ctl_t  ctl_o
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DISP    = 5'd1;
  localparam logic [4:0] S_PUT     = 5'd2;
  localparam logic [4:0] S_PF_RD   = 5'd3;
  localparam logic [4:0] S_PF_D1   = 5'd4;
  localparam logic [4:0] S_PF_EV   = 5'd5;
  localparam logic [4:0] S_PF_APP  = 5'd6;
  localparam logic [4:0] S_MG      = 5'd7;
  localparam logic [4:0] S_MG_RD   = 5'd8;
  localparam logic [4:0] S_MG_D1   = 5'd9;
  localparam logic [4:0] S_MG_EV   = 5'd10;
  localparam logic [4:0] S_DR      = 5'd11;
  localparam logic [4:0] S_DR_D1   = 5'd12;
  localparam logic [4:0] S_TK_RD   = 5'd13;
  localparam logic [4:0] S_TK_D1   = 5'd14;
  localparam logic [4:0] S_TK_EV   = 5'd15;
  localparam logic [4:0] S_TK_END  = 5'd16;
  localparam logic [4:0] S_TK_X1   = 5'd17;
  localparam logic [4:0] S_TK_X2   = 5'd18;
  localparam logic [4:0] S_TK_X3   = 5'd19;
  localparam logic [4:0] S_TK_X4   = 5'd20;
  localparam logic [4:0] S_TK_HEAD = 5'd21;
  localparam logic [4:0] S_TK_TAIL = 5'd22;
  localparam logic [4:0] S_TK_DROP = 5'd23;
  localparam logic [4:0] S_PG_RD   = 5'd24;
  localparam logic [4:0] S_PG_D1   = 5'd25;
  localparam logic [4:0] S_PG_EV   = 5'd26;
  localparam logic [4:0] S_FIN     = 5'd27;

  localparam logic [1:0] R_INS  = 2'd0;
  localparam logic [1:0] R_HEAD = 2'd1;
  localparam logic [1:0] R_TAIL = 2'd2;

  localparam logic [1:0] D_MG  = 2'd0;
  localparam logic [1:0] D_PG  = 2'd1;
  localparam logic [1:0] D_FIN = 2'd2;

  logic [4:0] state_q, state_d;
  logic [1:0] pret_q, pret_d;
  logic [1:0] dret_q, dret_d;
  logic [4:0] put_next;
  logic [4:0] drop_next;

  always_comb begin
    priority if (pret_q == R_INS) begin
      put_next = S_FIN;
    end else if (pret_q == R_HEAD) begin
      put_next = S_TK_TAIL;
    end else begin
      put_next = S_TK_DROP;
    end
    priority if (dret_q == D_MG) begin
      drop_next = S_MG;
    end else if (dret_q == D_PG) begin
      drop_next = S_PG_RD;
    end else begin
      drop_next = S_FIN;
    end
  end

  always_comb begin
    state_d   = state_q;
    pret_d    = pret_q;
    dret_d    = dret_q;
    ctl_o.op  = fetbf_pkg::OP_NOP;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.op = fetbf_pkg::OP_LATCH;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        unique case (st_i.cmd)
          fetbf_pkg::CMD_INSERT: begin
            ctl_o.op = fetbf_pkg::OP_INS_INIT;
            pret_d   = R_INS;
            state_d  = S_PUT;
          end
          fetbf_pkg::CMD_TAKE: begin
            ctl_o.op = fetbf_pkg::OP_TK_INIT;
            state_d  = S_TK_RD;
          end
          fetbf_pkg::CMD_PURGE: begin
            ctl_o.op = fetbf_pkg::OP_K0;
            state_d  = S_PG_RD;
          end
          fetbf_pkg::CMD_CLEAR: begin
            ctl_o.op = fetbf_pkg::OP_CLR;
            state_d  = S_FIN;
          end
        endcase
      end
      S_PUT: begin
        if (st_i.ext_zero) begin
          state_d = put_next;
        end else begin
          ctl_o.op = fetbf_pkg::OP_K0;
          state_d  = S_PF_RD;
        end
      end
      S_PF_RD: begin
        priority if (st_i.k_end) begin
          state_d = S_PF_APP;
        end else if (st_i.k_pin) begin
          ctl_o.op = fetbf_pkg::OP_KINC;
        end else begin
          ctl_o.op = fetbf_pkg::OP_RD;
          state_d  = S_PF_D1;
        end
      end
      S_PF_D1: begin
        ctl_o.op = fetbf_pkg::OP_CALC;
        state_d  = S_PF_EV;
      end
      S_PF_EV: begin
        if (st_i.pf_hit) begin
          ctl_o.op = fetbf_pkg::OP_PF_WR;
          state_d  = S_MG;
        end else begin
          ctl_o.op = fetbf_pkg::OP_KINC;
          state_d  = S_PF_RD;
        end
      end
      S_PF_APP: begin
        if (st_i.full) begin
          ctl_o.op = fetbf_pkg::OP_SET_DROP;
          state_d  = put_next;
        end else begin
          ctl_o.op = fetbf_pkg::OP_APPEND;
          state_d  = S_MG;
        end
      end
      S_MG: begin
        ctl_o.op = fetbf_pkg::OP_MG_INIT;
        state_d  = S_MG_RD;
      end
      S_MG_RD: begin
        priority if (st_i.k_end) begin
          state_d = put_next;
        end else if (st_i.k_skip) begin
          ctl_o.op = fetbf_pkg::OP_KINC;
        end else begin
          ctl_o.op = fetbf_pkg::OP_RD;
          state_d  = S_MG_D1;
        end
      end
      S_MG_D1: begin
        ctl_o.op = fetbf_pkg::OP_CALC;
        state_d  = S_MG_EV;
      end
      S_MG_EV: begin
        if (st_i.mg_hit) begin
          ctl_o.op = fetbf_pkg::OP_MG_WR;
          dret_d   = D_MG;
          state_d  = S_DR;
        end else begin
          ctl_o.op = fetbf_pkg::OP_KINC;
          state_d  = S_MG_RD;
        end
      end
      S_DR: begin
        if (st_i.dr_last) begin
          ctl_o.op = fetbf_pkg::OP_DR_DEC;
          state_d  = drop_next;
        end else begin
          ctl_o.op = fetbf_pkg::OP_RD_LAST;
          state_d  = S_DR_D1;
        end
      end
      S_DR_D1: begin
        ctl_o.op = fetbf_pkg::OP_DR_WR;
        state_d  = drop_next;
      end
      S_TK_RD: begin
        if (st_i.k_end) begin
          state_d = S_TK_END;
        end else begin
          ctl_o.op = fetbf_pkg::OP_RD;
          state_d  = S_TK_D1;
        end
      end
      S_TK_D1: begin
        ctl_o.op = fetbf_pkg::OP_CALC;
        state_d  = S_TK_EV;
      end
      S_TK_EV: begin
        ctl_o.op = fetbf_pkg::OP_TK_EV;
        state_d  = S_TK_RD;
      end
      S_TK_END: begin
        if (st_i.have) begin
          ctl_o.op = fetbf_pkg::OP_RD_BEST;
          state_d  = S_TK_X1;
        end else begin
          state_d = S_FIN;
        end
      end
      S_TK_X1: begin
        ctl_o.op = fetbf_pkg::OP_TK_X1;
        state_d  = S_TK_X2;
      end
      S_TK_X2: begin
        ctl_o.op = fetbf_pkg::OP_TK_X2;
        state_d  = S_TK_X3;
      end
      S_TK_X3: begin
        ctl_o.op = fetbf_pkg::OP_TK_X3;
        state_d  = S_TK_X4;
      end
      S_TK_X4: begin
        ctl_o.op = fetbf_pkg::OP_TK_X4;
        state_d  = S_TK_HEAD;
      end
      S_TK_HEAD: begin
        if (st_i.head) begin
          ctl_o.op = fetbf_pkg::OP_HEAD_EXT;
          pret_d   = R_HEAD;
          state_d  = S_PUT;
        end else begin
          state_d = S_TK_TAIL;
        end
      end
      S_TK_TAIL: begin
        if (st_i.tail_nz) begin
          ctl_o.op = fetbf_pkg::OP_TAIL_EXT;
          pret_d   = R_TAIL;
          state_d  = S_PUT;
        end else begin
          state_d = S_TK_DROP;
        end
      end
      S_TK_DROP: begin
        ctl_o.op = fetbf_pkg::OP_TK_DONE;
        dret_d   = D_FIN;
        state_d  = st_i.pin_valid ? S_DR : S_FIN;
      end
      S_PG_RD: begin
        if (st_i.k_end) begin
          state_d = S_FIN;
        end else begin
          ctl_o.op = fetbf_pkg::OP_RD;
          state_d  = S_PG_D1;
        end
      end
      S_PG_D1: begin
        ctl_o.op = fetbf_pkg::OP_CALC;
        state_d  = S_PG_EV;
      end
      S_PG_EV: begin
        if (st_i.purge_hit) begin
          ctl_o.op = fetbf_pkg::OP_DROPK;
          dret_d   = D_PG;
          state_d  = S_DR;
        end else begin
          ctl_o.op = fetbf_pkg::OP_KINC;
          state_d  = S_PG_RD;
        end
      end
      S_FIN: begin
        if (st_i.out_free) begin
          ctl_o.op = fetbf_pkg::OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pret_q  <= R_INS;
      dret_q  <= D_MG;
    end else begin
      state_q <= state_d;
      pret_q  <= pret_d;
      dret_q  <= dret_d;
    end
  end

endmodule

/* sv/fetbf_dp.sv */
`timescale 1ns / 1ps
// Datapath of the free extent table: hole memory, scan registers and result register.
module fetbf_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fetbf_pkg::ctl_t                  ctl_i,
  output fetbf_pkg::stat_t                 st_o,
  input  logic [fetbf_pkg::AlignW-1:0]     align_i,
  input  fetbf_pkg::in_item_t              in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output fetbf_pkg::out_item_t             out_item_o
);

  localparam int unsigned IdxW = fetbf_pkg::IdxW;
  localparam int unsigned CntW = fetbf_pkg::CntW;

  fetbf_pkg::hole_t mem_q [fetbf_pkg::MaxHoles];

  fetbf_pkg::in_item_t  in_q, in_d;
  fetbf_pkg::hole_t     rd_q;
  fetbf_pkg::out_item_t out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic [CntW-1:0] cnt_q, cnt_d, k_q, k_d, pin_q, pin_d;
  logic [IdxW-1:0] m_q, m_d, drop_q, drop_d, best_q, best_d;
  logic            have_q, have_d, took_q, took_d, dropped_q, dropped_d;

  fetbf_pkg::addr_t ms_q, ms_d, ml_q, ml_d, mend_q, mend_d;
  fetbf_pkg::addr_t exb_q, exb_d, exl_q, exl_d, exsum_q, exsum_d;
  fetbf_pkg::addr_t end_q, end_d, at_q, at_d, wst_q, wst_d, sum_q, sum_d;
  fetbf_pkg::addr_t lo_q, lo_d, bw_q, bw_d, hs_q, hs_d, hl_q, hl_d;
  fetbf_pkg::addr_t e_q, e_d, tail_q, tail_d, taken_q, taken_d;

  logic             re, we;
  logic [IdxW-1:0]  raddr, waddr;
  fetbf_pkg::hole_t wdata;
  logic [CntW-1:0]  lastc;
  logic             k_lt_m, hit_a, hit_b, fit;

  assign lastc  = cnt_q - CntW'(1);
  assign k_lt_m = (k_q < CntW'(m_q));
  assign hit_a  = (mend_q == rd_q.s);
  assign hit_b  = (end_q == ms_q);
  assign fit    = (at_q >= lo_q) && (at_q < end_q) && (in_q.length <= end_q - at_q);

  always_comb begin
    st_o.cmd       = fetbf_pkg::cmd_e'(in_q.cmd);
    st_o.k_end     = (k_q >= cnt_q);
    st_o.k_pin     = (k_q == pin_q);
    st_o.k_skip    = (k_q == CntW'(m_q)) || (k_q == pin_q);
    st_o.ext_zero  = (exb_q == '0) || (exl_q == '0);
    st_o.full      = (cnt_q >= CntW'(fetbf_pkg::MaxHoles));
    st_o.pf_hit    = (end_q == exb_q) || (exsum_q == rd_q.s);
    st_o.mg_hit    = hit_a || hit_b;
    st_o.dr_last   = (CntW'(drop_q) == lastc);
    st_o.have      = have_q;
    st_o.head      = (at_q > hs_q);
    st_o.tail_nz   = (tail_q != '0);
    st_o.pin_valid = (pin_q < cnt_q);
    st_o.purge_hit = (end_q <= in_q.floor_addr);
    st_o.out_free  = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    in_d = in_q;  out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    cnt_d = cnt_q;  k_d = k_q;  pin_d = pin_q;
    m_d = m_q;  drop_d = drop_q;  best_d = best_q;
    have_d = have_q;  took_d = took_q;  dropped_d = dropped_q;
    ms_d = ms_q;  ml_d = ml_q;  mend_d = mend_q;
    exb_d = exb_q;  exl_d = exl_q;  exsum_d = exsum_q;
    end_d = end_q;  at_d = at_q;  wst_d = wst_q;  sum_d = sum_q;
    lo_d = lo_q;  bw_d = bw_q;  hs_d = hs_q;  hl_d = hl_q;
    e_d = e_q;  tail_d = tail_q;  taken_d = taken_q;
    re = 1'b0;  raddr = k_q[IdxW-1:0];
    we = 1'b0;  waddr = k_q[IdxW-1:0];  wdata = rd_q;
    unique case (ctl_i.op)
      fetbf_pkg::OP_NOP: begin
      end
      fetbf_pkg::OP_LATCH: begin
        in_d      = in_item_i;
        taken_d   = '0;
        took_d    = 1'b0;
        dropped_d = 1'b0;
      end
      fetbf_pkg::OP_INS_INIT: begin
        exb_d = in_q.base_addr;
        exl_d = in_q.length;
        pin_d = fetbf_pkg::NoPin;
      end
      fetbf_pkg::OP_TK_INIT: begin
        lo_d   = fetbf_pkg::round_up(in_q.floor_addr, align_i);
        have_d = 1'b0;
        k_d    = '0;
        pin_d  = fetbf_pkg::NoPin;
      end
      fetbf_pkg::OP_K0: begin
        k_d = '0;
      end
      fetbf_pkg::OP_CLR: begin
        cnt_d = '0;
      end
      fetbf_pkg::OP_KINC: begin
        k_d = k_q + CntW'(1);
      end
      fetbf_pkg::OP_RD: begin
        re = 1'b1;
      end
      fetbf_pkg::OP_CALC: begin
        end_d   = rd_q.s + rd_q.l;
        at_d    = fetbf_pkg::round_up(rd_q.s, align_i);
        wst_d   = rd_q.l - in_q.length;
        exsum_d = exb_q + exl_q;
        sum_d   = rd_q.l + ml_q;
      end
      fetbf_pkg::OP_PF_WR: begin
        we      = 1'b1;
        wdata.s = (end_q == exb_q) ? rd_q.s : exb_q;
        wdata.l = rd_q.l + exl_q;
        ms_d    = wdata.s;
        ml_d    = wdata.l;
        m_d     = k_q[IdxW-1:0];
      end
      fetbf_pkg::OP_SET_DROP: begin
        dropped_d = 1'b1;
      end
      fetbf_pkg::OP_APPEND: begin
        we      = 1'b1;
        waddr   = cnt_q[IdxW-1:0];
        wdata.s = exb_q;
        wdata.l = exl_q;
        ms_d    = exb_q;
        ml_d    = exl_q;
        m_d     = cnt_q[IdxW-1:0];
        cnt_d   = cnt_q + CntW'(1);
      end
      fetbf_pkg::OP_MG_INIT: begin
        mend_d = ms_q + ml_q;
        k_d    = '0;
      end
      fetbf_pkg::OP_MG_WR: begin
        we = 1'b1;
        if (k_lt_m) begin
          waddr   = k_q[IdxW-1:0];
          wdata.s = hit_b ? rd_q.s : ms_q;
          drop_d  = m_q;
          m_d     = k_q[IdxW-1:0];
        end else begin
          waddr   = m_q;
          wdata.s = hit_a ? ms_q : rd_q.s;
          drop_d  = k_q[IdxW-1:0];
        end
        wdata.l = sum_q;
        ms_d    = wdata.s;
        ml_d    = sum_q;
      end
      fetbf_pkg::OP_DR_DEC: begin
        cnt_d = lastc;
      end
      fetbf_pkg::OP_RD_LAST: begin
        re    = 1'b1;
        raddr = lastc[IdxW-1:0];
      end
      fetbf_pkg::OP_DR_WR: begin
        we    = 1'b1;
        waddr = drop_q;
        wdata = rd_q;
        if (pin_q == lastc) begin
          pin_d = CntW'(drop_q);
        end
        cnt_d = lastc;
      end
      fetbf_pkg::OP_TK_EV: begin
        if (fit && (!have_q || wst_q < bw_q)) begin
          have_d = 1'b1;
          bw_d   = wst_q;
          best_d = k_q[IdxW-1:0];
        end
        k_d = k_q + CntW'(1);
      end
      fetbf_pkg::OP_RD_BEST: begin
        re    = 1'b1;
        raddr = best_q;
      end
      fetbf_pkg::OP_TK_X1: begin
        hs_d  = rd_q.s;
        hl_d  = rd_q.l;
        at_d  = fetbf_pkg::round_up(rd_q.s, align_i);
        pin_d = CntW'(best_q);
      end
      fetbf_pkg::OP_TK_X2: begin
        e_d     = at_q + in_q.length;
        taken_d = at_q;
      end
      fetbf_pkg::OP_TK_X3: begin
        tail_d = e_q - hs_q;
      end
      fetbf_pkg::OP_TK_X4: begin
        tail_d = hl_q - tail_q;
      end
      fetbf_pkg::OP_HEAD_EXT: begin
        exb_d = hs_q;
        exl_d = at_q - hs_q;
      end
      fetbf_pkg::OP_TAIL_EXT: begin
        exb_d = e_q;
        exl_d = tail_q;
      end
      fetbf_pkg::OP_TK_DONE: begin
        took_d  = 1'b1;
        drop_d  = pin_q[IdxW-1:0];
      end
      fetbf_pkg::OP_DROPK: begin
        drop_d = k_q[IdxW-1:0];
      end
      fetbf_pkg::OP_EMIT: begin
        out_d.taken_addr = taken_q;
        out_d.took       = took_q;
        out_d.dropped    = dropped_q;
        out_d.hole_total = cnt_q;
        out_valid_d      = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      k_q         <= '0;
      pin_q       <= fetbf_pkg::NoPin;
      have_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      pin_q       <= pin_d;
      have_q      <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= in_d;  out_q <= out_d;
    m_q <= m_d;  drop_q <= drop_d;  best_q <= best_d;
    took_q <= took_d;  dropped_q <= dropped_d;
    ms_q <= ms_d;  ml_q <= ml_d;  mend_q <= mend_d;
    exb_q <= exb_d;  exl_q <= exl_d;  exsum_q <= exsum_d;
    end_q <= end_d;  at_q <= at_d;  wst_q <= wst_d;  sum_q <= sum_d;
    lo_q <= lo_d;  bw_q <= bw_d;  hs_q <= hs_d;  hl_q <= hl_d;
    e_q <= e_d;  tail_q <= tail_d;  taken_q <= taken_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
